@@ rtl/tlbm_pkg.sv @@
// Shared constants, opcodes and request/response types for the translation buffer.
`timescale 1ns / 1ps
`default_nettype none

package tlbm_pkg;

    localparam int TLB_ENTRIES = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int PID_BITS   = 16;
    localparam int PAGE_BITS  = 36;
    localparam int FRAME_BITS = 24;
    localparam int OP_BITS    = 2;

    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_FLUSH  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_INVAL  = 2'd3;

    typedef struct packed {
        logic [OP_BITS-1:0]    opcode;
        logic [PID_BITS-1:0]   pid;
        logic [PAGE_BITS-1:0]  page_number;
        logic [FRAME_BITS-1:0] frame_number;
    } in_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_out;
        logic                  found;
    } out_t;

    typedef struct packed {
        logic lookup;
        logic insert;
        logic flush;
        logic inval;
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [PID_BITS-1:0]   pid;
        logic [PAGE_BITS-1:0]  page;
        logic [FRAME_BITS-1:0] frame;
    } req_t;

endpackage

`default_nettype wire

@@ rtl/tlbm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tlbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tlbm_front.sv @@
// Front stage: takes a request, decodes its opcode and hands it to the queue.
`timescale 1ns / 1ps
`default_nettype none

module tlbm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire tlbm_pkg::in_t in_data,
    output logic               push_valid,
    input  wire logic          push_ready,
    output tlbm_pkg::req_t     push_data
);

    import tlbm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    req_t  req_reg;
    req_t  req_next;
    kind_t kind;

    always_comb
    begin
        kind = '0;
        unique case (in_data.opcode)
            OP_LOOKUP: kind.lookup = 1'b1;
            OP_INSERT: kind.insert = 1'b1;
            OP_FLUSH:  kind.flush  = 1'b1;
            OP_INVAL:  kind.inval  = 1'b1;
        endcase
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = req_reg;

    always_comb
    begin
        valid_next = valid_reg;
        req_next   = req_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                req_next.kind  = kind;
                req_next.pid   = in_data.pid;
                req_next.page  = in_data.page_number;
                req_next.frame = in_data.frame_number;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

endmodule

`default_nettype wire

@@ rtl/tlbm_fifo.sv @@
// Short request queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none

module tlbm_fifo #(
    parameter int DEPTH = tlbm_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire tlbm_pkg::req_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output tlbm_pkg::req_t      pop_data
);

    import tlbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    req_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] wptr_next;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W-1:0] rptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tlbm_back.sv @@
// Back stage: tag match, valid bits, LRU matrix, frame store and response register.
`timescale 1ns / 1ps
`default_nettype none

module tlbm_back #(
    parameter int ENTRIES = tlbm_pkg::TLB_ENTRIES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire tlbm_pkg::req_t pop_data,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tlbm_pkg::out_t      rsp
);

    import tlbm_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [ENTRIES-1:0]   lru_reg  [ENTRIES];
    logic [ENTRIES-1:0]   lru_next [ENTRIES];
    logic [PID_BITS-1:0]  pid_reg  [ENTRIES];
    logic [PAGE_BITS-1:0] page_reg [ENTRIES];

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic                  found_reg;
    logic                  found_next;
    logic [FRAME_BITS-1:0] frame_rdata;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] pid_match;
    logic [ENTRIES-1:0] zero_row;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   zero_idx;
    logic [IDX_W-1:0]   ins_idx;
    logic [IDX_W-1:0]   touch_idx;
    logic               hit_any;
    logic               free_any;
    logic               ins_ok;
    logic               issue;
    logic               do_insert;
    logic               touch_en;

    assign pop_ready = !out_valid_reg || rsp_ready;
    assign issue     = pop_valid && pop_ready;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            pid_match[i] = (pid_reg[i] == pop_data.pid);
            match[i]     = valid_reg[i] && pid_match[i] && (page_reg[i] == pop_data.page);
            zero_row[i]  = (lru_reg[i] == '0);
        end
    end

    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        zero_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (zero_row[i])
            begin
                zero_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any   = |match;
    assign free_any  = ~&valid_reg;
    assign ins_ok    = free_any || (|zero_row);
    assign ins_idx   = free_any ? free_idx : zero_idx;
    assign do_insert = issue && pop_data.kind.insert && ins_ok;
    assign touch_en  = do_insert || (issue && pop_data.kind.lookup && hit_any);
    assign touch_idx = pop_data.kind.insert ? ins_idx : match_idx;

    // Touch: row set to ones, then the column cleared everywhere.
    always_comb
    begin
        for (int r = 0; r < ENTRIES; r++)
        begin
            lru_next[r] = lru_reg[r];
            if (touch_en)
            begin
                if (touch_idx == IDX_W'(r))
                begin
                    lru_next[r] = '1;
                end
                lru_next[r][touch_idx] = 1'b0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (issue)
        begin
            priority if (pop_data.kind.insert)
            begin
                if (ins_ok)
                begin
                    valid_next[ins_idx] = 1'b1;
                end
            end
            else if (pop_data.kind.flush)
            begin
                valid_next = valid_reg & ~pid_match;
            end
            else if (pop_data.kind.inval)
            begin
                if (hit_any)
                begin
                    valid_next[match_idx] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            hit_next       = pop_data.kind.lookup && hit_any;
            found_next     = pop_data.kind.inval && hit_any;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < ENTRIES; r++)
            begin
                lru_reg[r] <= '0;
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            for (int r = 0; r < ENTRIES; r++)
            begin
                lru_reg[r] <= lru_next[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        found_reg <= found_next;
        if (do_insert)
        begin
            pid_reg[ins_idx]  <= pop_data.pid;
            page_reg[ins_idx] <= pop_data.page;
        end
    end

    tlbm_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (do_insert),
        .waddr (ins_idx),
        .wdata (pop_data.frame),
        .re    (issue && pop_data.kind.lookup),
        .raddr (match_idx),
        .rdata (frame_rdata)
    );

    assign rsp_valid     = out_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.frame_out = hit_reg ? frame_rdata : '0;
    assign rsp.found     = found_reg;

endmodule

`default_nettype wire

@@ rtl/tlb_with_matrix_lru.sv @@
// Top level of the fully associative translation buffer with matrix LRU.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative TLB, ENTRIES entries tagged by pid and page, matrix LRU
// replacement. A request passes a decode register and a two-entry queue, then
// the back stage matches every entry in parallel, updates valid bits and the
// LRU matrix, and registers the response; the frame store is a RAM with a
// registered read, so a lookup result appears in the cycle after it is issued.
// One request per cycle is sustained while responses are taken; with no
// back-pressure a request passes the decode register, a queue slot and the
// response register in turn. Requests are executed strictly in order.
// No clearing pass after reset: valid bits and LRU rows reset directly.

module tlb_with_matrix_lru #(
    parameter int ENTRIES = tlbm_pkg::TLB_ENTRIES
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tlbm_pkg::in_t  req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tlbm_pkg::out_t      rsp
);

    import tlbm_pkg::*;

    logic push_valid;
    logic push_ready;
    req_t push_data;
    logic pop_valid;
    logic pop_ready;
    req_t pop_data;

    tlbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .in_data    (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tlbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tlbm_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
